// ===== rtl/apr_pkg.sv =====
package apr_pkg;

    localparam int RULE_SLOTS_DEF = 8;

    localparam int SLOT_W   = 3;
    localparam int TYPE_W   = 4;
    localparam int HALF_W   = 64;
    localparam int ADDR_W   = 2 * HALF_W;
    localparam int DETAIL_W = 8;
    localparam int PORT_W   = 16;
    localparam int V4_W     = 32;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // rule type codes; codes above RT_PORT_RANGE are stored but match nothing
    localparam logic [TYPE_W-1:0] RT_EMPTY      = 4'd0;
    localparam logic [TYPE_W-1:0] RT_ANY_ADDR   = 4'd1;
    localparam logic [TYPE_W-1:0] RT_V4_WILD    = 4'd2;
    localparam logic [TYPE_W-1:0] RT_V4_RANGE   = 4'd3;
    localparam logic [TYPE_W-1:0] RT_V6_EXACT   = 4'd4;
    localparam logic [TYPE_W-1:0] RT_V6_PREFIX  = 4'd5;
    localparam logic [TYPE_W-1:0] RT_V6_RANGE   = 4'd6;
    localparam logic [TYPE_W-1:0] RT_ANY_PORT   = 4'd7;
    localparam logic [TYPE_W-1:0] RT_PORT_EXACT = 4'd8;
    localparam logic [TYPE_W-1:0] RT_PORT_RANGE = 4'd9;

    // one lookup beat walking the cell chain
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic              is_v6;
        logic [PORT_W-1:0] port;
        logic              v6_special;
        logic              addr_hit;
        logic              port_hit;
    } t_beat;

    // rule write broadcast to all cells
    typedef struct packed {
        logic                en;
        logic [SLOT_W-1:0]   slot;
        logic [TYPE_W-1:0]   rule_type;
        logic [ADDR_W-1:0]   first;
        logic [ADDR_W-1:0]   second;
        logic [DETAIL_W-1:0] detail;
    } t_rule_wr;

endpackage

// ===== rtl/apr_cell.sv =====
module apr_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  apr_pkg::t_rule_wr i_wr,
    input  apr_pkg::t_beat   i_beat,
    output apr_pkg::t_beat   o_beat
);

    logic [apr_pkg::TYPE_W-1:0]   r_type;
    logic [apr_pkg::ADDR_W-1:0]   r_first;
    logic [apr_pkg::ADDR_W-1:0]   r_second;
    logic [apr_pkg::DETAIL_W-1:0] r_detail;
    apr_pkg::t_beat               r_beat;
    apr_pkg::t_beat               n_beat;

    logic                         w_sel;
    logic [apr_pkg::V4_W-1:0]     w_ip4;
    logic [apr_pkg::V4_W-1:0]     w_pat4;
    logic                         w_wild_ok;
    logic [apr_pkg::ADDR_W-1:0]   w_mask;
    logic [apr_pkg::HALF_W-1:0]   w_port;
    logic                         w_addr_match;
    logic                         w_port_match;

    assign w_sel = i_wr.en && (int'(i_wr.slot) == CELL_INDEX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type <= apr_pkg::RT_EMPTY;
        end else if (w_sel) begin
            r_type <= i_wr.rule_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_first  <= i_wr.first;
            r_second <= i_wr.second;
            r_detail <= i_wr.detail;
        end
    end

    assign w_ip4  = i_beat.addr[apr_pkg::V4_W-1:0];
    assign w_pat4 = r_first[apr_pkg::V4_W-1:0];
    assign w_port = {{(apr_pkg::HALF_W - apr_pkg::PORT_W){1'b0}}, i_beat.port};
    // prefix mask: lengths of 128 and up give all ones, validity checked below
    assign w_mask = ~({apr_pkg::ADDR_W{1'b1}} >> r_detail);

    always_comb begin
        w_wild_ok = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (!r_detail[3-k] && (w_pat4[31-8*k -: 8] != w_ip4[31-8*k -: 8])) begin
                w_wild_ok = 1'b0;
            end
        end
    end

    always_comb begin
        w_addr_match = 1'b0;
        w_port_match = 1'b0;
        unique case (r_type)
            apr_pkg::RT_ANY_ADDR:   w_addr_match = 1'b1;
            apr_pkg::RT_V4_WILD:    w_addr_match = !i_beat.is_v6 && w_wild_ok;
            apr_pkg::RT_V4_RANGE:   w_addr_match = !i_beat.is_v6
                                        && (w_ip4 >= w_pat4)
                                        && (w_ip4 <= r_second[apr_pkg::V4_W-1:0]);
            apr_pkg::RT_V6_EXACT:   w_addr_match = i_beat.is_v6 && (i_beat.addr == r_first);
            apr_pkg::RT_V6_PREFIX:  w_addr_match = i_beat.is_v6
                                        && (r_detail <= 8'(apr_pkg::ADDR_W))
                                        && (((i_beat.addr ^ r_first) & w_mask) == '0);
            apr_pkg::RT_V6_RANGE:   w_addr_match = i_beat.is_v6
                                        && (i_beat.addr >= r_first)
                                        && (i_beat.addr <= r_second);
            apr_pkg::RT_ANY_PORT:   w_port_match = 1'b1;
            apr_pkg::RT_PORT_EXACT: w_port_match = (w_port == r_first[apr_pkg::HALF_W-1:0]);
            apr_pkg::RT_PORT_RANGE: w_port_match = (w_port >= r_first[apr_pkg::HALF_W-1:0])
                                        && (w_port <= r_second[apr_pkg::HALF_W-1:0]);
            default: begin
                w_addr_match = 1'b0;
                w_port_match = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_beat          = i_beat;
        n_beat.addr_hit = i_beat.addr_hit || w_addr_match;
        n_beat.port_hit = i_beat.port_hit || w_port_match;
    end

    // advance the beat one cell each cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= n_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat.addr       <= n_beat.addr;
        r_beat.is_v6      <= n_beat.is_v6;
        r_beat.port       <= n_beat.port;
        r_beat.v6_special <= n_beat.v6_special;
        r_beat.addr_hit   <= n_beat.addr_hit;
        r_beat.port_hit   <= n_beat.port_hit;
    end

    assign o_beat = r_beat;

endmodule

// ===== rtl/address_port_rule_matcher.sv =====
// A lookup beat is registered in each rule cell in turn, then in the output register,
// and its result shows on o_valid. A new lookup is taken only after the last one's beat
// has walked through the chain of rule cells, one cell per cycle.
// Rule writes are taken whenever no lookup is in the chain and no result waits in the skid.
// Reset (i_rst_n low, synchronous) empties every rule slot and clears all valids.
module address_port_rule_matcher #(
    parameter int RULE_SLOTS = apr_pkg::RULE_SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_op,
    input  logic [apr_pkg::SLOT_W-1:0]         i_slot,
    input  logic [apr_pkg::TYPE_W-1:0]         i_rule_type,
    input  logic [apr_pkg::HALF_W-1:0]         i_first_upper,
    input  logic [apr_pkg::HALF_W-1:0]         i_first_lower,
    input  logic [apr_pkg::HALF_W-1:0]         i_second_upper,
    input  logic [apr_pkg::HALF_W-1:0]         i_second_lower,
    input  logic [apr_pkg::DETAIL_W-1:0]       i_detail,
    input  logic [apr_pkg::HALF_W-1:0]         i_addr_upper,
    input  logic [apr_pkg::HALF_W-1:0]         i_addr_lower,
    input  logic                               i_addr_is_v6,
    input  logic [apr_pkg::PORT_W-1:0]         i_port_number,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_address_hit,
    output logic                               o_port_hit,
    output logic                               o_v6_special
);

    // Special IPv6 ranges: multicast, link-local, site-local, unspecified.
    function automatic logic v6_special(input logic [apr_pkg::ADDR_W-1:0] addr);
        logic [7:0] b0;
        logic [7:0] b1;
        b0 = addr[apr_pkg::ADDR_W-1 -: 8];
        b1 = addr[apr_pkg::ADDR_W-9 -: 8];
        return (b0 == 8'hFF)
            || ((b0 == 8'hFE) && ((b1 & 8'hC0) == 8'h80))
            || ((b0 == 8'hFE) && ((b1 & 8'hC0) == 8'hC0))
            || (addr == '0);
    endfunction

    logic              w_accept;
    logic              w_lookup;
    logic              w_take;
    logic              r_busy;

    apr_pkg::t_rule_wr w_wr;
    apr_pkg::t_beat    w_link [RULE_SLOTS+1];
    apr_pkg::t_beat    w_tail;

    // output register plus one skid entry
    logic              r_out_valid;
    logic              r_out_ahit;
    logic              r_out_phit;
    logic              r_out_spec;
    logic              r_skid_valid;
    logic              r_skid_ahit;
    logic              r_skid_phit;
    logic              r_skid_spec;

    // Hold off new beats while a lookup walks the chain or a result sits in the skid.
    // Writes must wait too, so no rule changes under a lookup in flight.
    assign o_stall  = r_busy || r_skid_valid;
    assign w_accept = i_valid && !o_stall;
    assign w_lookup = w_accept && (i_op == apr_pkg::OP_LOOKUP);
    assign w_take   = r_out_valid && !i_stall;

    // Broadcast a rule write; only the cell whose index matches the slot keeps it.
    always_comb begin
        w_wr.en        = w_accept && (i_op == apr_pkg::OP_WRITE);
        w_wr.slot      = i_slot;
        w_wr.rule_type = i_rule_type;
        w_wr.first     = {i_first_upper, i_first_lower};
        w_wr.second    = {i_second_upper, i_second_lower};
        w_wr.detail    = i_detail;
    end

    // Inject the lookup beat at the head of the chain with cleared hit flags.
    always_comb begin
        w_link[0].valid      = w_lookup;
        w_link[0].addr       = {i_addr_upper, i_addr_lower};
        w_link[0].is_v6      = i_addr_is_v6;
        w_link[0].port       = i_port_number;
        w_link[0].v6_special = i_addr_is_v6 && v6_special({i_addr_upper, i_addr_lower});
        w_link[0].addr_hit   = 1'b0;
        w_link[0].port_hit   = 1'b0;
    end

    // One cell per rule slot; each ORs its own match into the passing beat.
    for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
        apr_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr),
            .i_beat  (w_link[g]),
            .o_beat  (w_link[g+1])
        );
    end

    assign w_tail = w_link[RULE_SLOTS];

    // Busy from acceptance of a lookup until its beat leaves the last cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_lookup) begin
            r_busy <= 1'b1;
        end else if (w_tail.valid) begin
            r_busy <= 1'b0;
        end
    end

    // Drain the skid first, then the tail; park the tail in the skid when the
    // output register is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= w_tail.valid;
            end else begin
                r_out_valid  <= w_tail.valid;
            end
        end else if (w_tail.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_ahit <= r_skid_ahit;
                r_out_phit <= r_skid_phit;
                r_out_spec <= r_skid_spec;
            end else begin
                r_out_ahit <= w_tail.addr_hit;
                r_out_phit <= w_tail.port_hit;
                r_out_spec <= w_tail.v6_special;
            end
        end
        if (w_tail.valid) begin
            r_skid_ahit <= w_tail.addr_hit;
            r_skid_phit <= w_tail.port_hit;
            r_skid_spec <= w_tail.v6_special;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_address_hit = r_out_ahit;
    assign o_port_hit    = r_out_phit;
    assign o_v6_special  = r_out_spec;

endmodule

// ===== rtl/apr_checker.sv =====
module apr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic i_op,
    input logic o_valid,
    input logic i_stall,
    input logic o_address_hit,
    input logic o_port_hit,
    input logic o_v6_special
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_address_hit) && $stable(o_port_hit)
            && $stable(o_v6_special))
        else $error("result payload changed while stalled");

    // an accepted lookup occupies the chain on the next cycle
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_op == apr_pkg::OP_LOOKUP) |=> o_stall)
        else $error("lookup accepted without blocking the input");

    // a rule write never blocks the following beat
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_op == apr_pkg::OP_WRITE) |=> !o_stall)
        else $error("rule write left the input stalled");

endmodule

bind address_port_rule_matcher apr_checker u_apr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_op          (i_op),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_address_hit (o_address_hit),
    .o_port_hit    (o_port_hit),
    .o_v6_special  (o_v6_special)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int RULE_SLOTS = apr_pkg::RULE_SLOTS_DEF;

    // One beat on the request channel, either a rule write or a lookup.
    typedef struct {
        logic                         op;
        logic [apr_pkg::SLOT_W-1:0]   slot;
        logic [apr_pkg::TYPE_W-1:0]   rule_type;
        logic [apr_pkg::HALF_W-1:0]   first_upper;
        logic [apr_pkg::HALF_W-1:0]   first_lower;
        logic [apr_pkg::HALF_W-1:0]   second_upper;
        logic [apr_pkg::HALF_W-1:0]   second_lower;
        logic [apr_pkg::DETAIL_W-1:0] detail;
        logic [apr_pkg::HALF_W-1:0]   addr_upper;
        logic [apr_pkg::HALF_W-1:0]   addr_lower;
        logic                         addr_is_v6;
        logic [apr_pkg::PORT_W-1:0]   port_number;
    } t_rule_beat;

    // What one lookup is expected to answer.
    typedef struct {
        logic addr_hit;
        logic port_hit;
        logic v6_special;
    } t_lookup_verdict;

    logic                         i_clk;
    logic                         i_rst_n        = 1'b0;
    logic                         i_valid        = 1'b0;
    logic                         o_stall;
    logic                         i_op           = apr_pkg::OP_WRITE;
    logic [apr_pkg::SLOT_W-1:0]   i_slot         = '0;
    logic [apr_pkg::TYPE_W-1:0]   i_rule_type    = apr_pkg::RT_EMPTY;
    logic [apr_pkg::HALF_W-1:0]   i_first_upper  = '0;
    logic [apr_pkg::HALF_W-1:0]   i_first_lower  = '0;
    logic [apr_pkg::HALF_W-1:0]   i_second_upper = '0;
    logic [apr_pkg::HALF_W-1:0]   i_second_lower = '0;
    logic [apr_pkg::DETAIL_W-1:0] i_detail       = '0;
    logic [apr_pkg::HALF_W-1:0]   i_addr_upper   = '0;
    logic [apr_pkg::HALF_W-1:0]   i_addr_lower   = '0;
    logic                         i_addr_is_v6   = 1'b0;
    logic [apr_pkg::PORT_W-1:0]   i_port_number  = '0;
    logic                         o_valid;
    logic                         i_stall        = 1'b0;
    logic                         o_address_hit;
    logic                         o_port_hit;
    logic                         o_v6_special;

    // Shadow copy of the rule table, updated as each write beat is accepted.
    logic [apr_pkg::TYPE_W-1:0]   rule_kind   [RULE_SLOTS];
    logic [apr_pkg::ADDR_W-1:0]   rule_first  [RULE_SLOTS];
    logic [apr_pkg::ADDR_W-1:0]   rule_second [RULE_SLOTS];
    logic [apr_pkg::DETAIL_W-1:0] rule_detail [RULE_SLOTS];

    // Verdicts of accepted lookups still waiting for their result beat.
    t_lookup_verdict verdicts_due[$];

    int fault_count = 0;
    int stall_left  = 0;
    // When set, both sides run flat out with no idling.
    bit steady      = 1'b0;

    address_port_rule_matcher #(
        .RULE_SLOTS(RULE_SLOTS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_slot         (i_slot),
        .i_rule_type    (i_rule_type),
        .i_first_upper  (i_first_upper),
        .i_first_lower  (i_first_lower),
        .i_second_upper (i_second_upper),
        .i_second_lower (i_second_lower),
        .i_detail       (i_detail),
        .i_addr_upper   (i_addr_upper),
        .i_addr_lower   (i_addr_lower),
        .i_addr_is_v6   (i_addr_is_v6),
        .i_port_number  (i_port_number),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_address_hit  (o_address_hit),
        .o_port_hit     (o_port_hit),
        .o_v6_special   (o_v6_special)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Idle length: zero most of the time, a short gap often, a long one rarely.
    function automatic int idle_span(input int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Leading ones for an IPv6 prefix of plen bits; plen is at most 128 here.
    function automatic logic [apr_pkg::ADDR_W-1:0] prefix_mask(
            input logic [apr_pkg::DETAIL_W-1:0] plen);
        if (plen == 0) return '0;
        return {apr_pkg::ADDR_W{1'b1}} << (apr_pkg::ADDR_W - plen);
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Compare the four octets, skipping those marked as wildcards (bit 3 = first octet).
    function automatic bit v4_octets_match(input logic [apr_pkg::V4_W-1:0] pat,
                                           input logic [apr_pkg::DETAIL_W-1:0] wild,
                                           input logic [apr_pkg::V4_W-1:0] ip);
        for (int k = 0; k < 4; k++) begin
            if (!wild[3-k] && pat[31-8*k -: 8] != ip[31-8*k -: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Walk every slot and fold its address and port match into the verdict.
    function automatic t_lookup_verdict match_verdict(
            input logic v6,
            input logic [apr_pkg::ADDR_W-1:0] addr,
            input logic [apr_pkg::PORT_W-1:0] port);
        t_lookup_verdict            v;
        logic [apr_pkg::V4_W-1:0]   ip4;
        logic [apr_pkg::HALF_W-1:0] wide_port;
        logic [7:0]                 b0;
        logic [7:0]                 b1;
        v = '{default: 1'b0};
        ip4 = addr[apr_pkg::V4_W-1:0];
        wide_port = {48'd0, port};
        for (int s = 0; s < RULE_SLOTS; s++) begin
            case (rule_kind[s])
                apr_pkg::RT_ANY_ADDR: v.addr_hit = 1'b1;
                apr_pkg::RT_V4_WILD: begin
                    if (!v6 && v4_octets_match(rule_first[s][apr_pkg::V4_W-1:0],
                                               rule_detail[s], ip4))
                        v.addr_hit = 1'b1;
                end
                apr_pkg::RT_V4_RANGE: begin
                    if (!v6 && ip4 >= rule_first[s][apr_pkg::V4_W-1:0]
                            && ip4 <= rule_second[s][apr_pkg::V4_W-1:0])
                        v.addr_hit = 1'b1;
                end
                apr_pkg::RT_V6_EXACT: begin
                    if (v6 && addr == rule_first[s]) v.addr_hit = 1'b1;
                end
                apr_pkg::RT_V6_PREFIX: begin
                    // a length above 128 never matches
                    if (v6 && rule_detail[s] <= 8'd128
                           && ((addr ^ rule_first[s]) & prefix_mask(rule_detail[s])) == '0)
                        v.addr_hit = 1'b1;
                end
                apr_pkg::RT_V6_RANGE: begin
                    if (v6 && addr >= rule_first[s] && addr <= rule_second[s])
                        v.addr_hit = 1'b1;
                end
                apr_pkg::RT_ANY_PORT: v.port_hit = 1'b1;
                apr_pkg::RT_PORT_EXACT: begin
                    if (wide_port == rule_first[s][apr_pkg::HALF_W-1:0]) v.port_hit = 1'b1;
                end
                apr_pkg::RT_PORT_RANGE: begin
                    if (wide_port >= rule_first[s][apr_pkg::HALF_W-1:0]
                            && wide_port <= rule_second[s][apr_pkg::HALF_W-1:0])
                        v.port_hit = 1'b1;
                end
                default: ;
            endcase
        end
        // multicast, link-local, site-local, unspecified
        b0 = addr[127:120];
        b1 = addr[119:112];
        v.v6_special = v6 && (b0 == 8'hFF
                              || (b0 == 8'hFE && (b1 & 8'hC0) == 8'h80)
                              || (b0 == 8'hFE && (b1 & 8'hC0) == 8'hC0)
                              || addr == '0);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Beat builders; unused fields carry junk to show they are ignored.
    // ------------------------------------------------------------------

    function automatic t_rule_beat make_rule(input logic [apr_pkg::SLOT_W-1:0] slot,
                                             input logic [apr_pkg::TYPE_W-1:0] kind,
                                             input logic [apr_pkg::ADDR_W-1:0] first,
                                             input logic [apr_pkg::ADDR_W-1:0] second,
                                             input logic [apr_pkg::DETAIL_W-1:0] detail);
        t_rule_beat b;
        b.op           = apr_pkg::OP_WRITE;
        b.slot         = slot;
        b.rule_type    = kind;
        b.first_upper  = first[apr_pkg::ADDR_W-1:apr_pkg::HALF_W];
        b.first_lower  = first[apr_pkg::HALF_W-1:0];
        b.second_upper = second[apr_pkg::ADDR_W-1:apr_pkg::HALF_W];
        b.second_lower = second[apr_pkg::HALF_W-1:0];
        b.detail       = detail;
        b.addr_upper   = rand64();
        b.addr_lower   = rand64();
        b.addr_is_v6   = 1'($urandom_range(0, 1));
        b.port_number  = 16'($urandom);
        return b;
    endfunction

    function automatic t_rule_beat make_lookup(input logic v6,
                                               input logic [apr_pkg::ADDR_W-1:0] addr,
                                               input logic [apr_pkg::PORT_W-1:0] port);
        t_rule_beat b;
        b.op           = apr_pkg::OP_LOOKUP;
        b.slot         = apr_pkg::SLOT_W'($urandom);
        b.rule_type    = apr_pkg::TYPE_W'($urandom);
        b.first_upper  = rand64();
        b.first_lower  = rand64();
        b.second_upper = rand64();
        b.second_lower = rand64();
        b.detail       = apr_pkg::DETAIL_W'($urandom);
        b.addr_upper   = addr[apr_pkg::ADDR_W-1:apr_pkg::HALF_W];
        b.addr_lower   = addr[apr_pkg::HALF_W-1:0];
        b.addr_is_v6   = v6;
        b.port_number  = port;
        return b;
    endfunction

    // Random rule with well-formed content most of the time.
    function automatic t_rule_beat draw_rule();
        logic [apr_pkg::TYPE_W-1:0]   kind;
        logic [apr_pkg::ADDR_W-1:0]   first;
        logic [apr_pkg::ADDR_W-1:0]   second;
        logic [apr_pkg::ADDR_W-1:0]   span;
        logic [apr_pkg::ADDR_W-1:0]   hold;
        logic [apr_pkg::DETAIL_W-1:0] detail;
        logic [apr_pkg::TYPE_W-1:0]   common_kinds[7];
        int                           r;
        common_kinds = '{apr_pkg::RT_V4_WILD, apr_pkg::RT_V4_RANGE, apr_pkg::RT_V6_EXACT,
                         apr_pkg::RT_V6_PREFIX, apr_pkg::RT_V6_RANGE,
                         apr_pkg::RT_PORT_EXACT, apr_pkg::RT_PORT_RANGE};
        r = $urandom_range(0, 99);
        // keep catch-all rules rare so that hits stay informative
        if (r < 3)       kind = apr_pkg::RT_ANY_ADDR;
        else if (r < 6)  kind = apr_pkg::RT_ANY_PORT;
        else if (r < 10) kind = apr_pkg::RT_EMPTY;
        else if (r < 14) kind = apr_pkg::TYPE_W'($urandom_range(10, 15));
        else             kind = common_kinds[$urandom_range(0, 6)];
        first  = {rand64(), rand64()};
        second = {rand64(), rand64()};
        detail = apr_pkg::DETAIL_W'($urandom_range(0, 128));
        span   = $urandom_range(0, 1) ? apr_pkg::ADDR_W'($urandom_range(0, 4096))
                                      : {rand64() >> 40, rand64()};
        case (kind)
            apr_pkg::RT_V4_RANGE:
                second[apr_pkg::V4_W-1:0] = first[apr_pkg::V4_W-1:0]
                                            + span[apr_pkg::V4_W-1:0];
            apr_pkg::RT_V6_RANGE: second = first + span;
            apr_pkg::RT_PORT_EXACT, apr_pkg::RT_PORT_RANGE: begin
                // mostly real port values; the rest lie above 65535
                if ($urandom_range(0, 9) != 0) begin
                    first[apr_pkg::HALF_W-1:0]  = {48'd0, 16'($urandom)};
                    second[apr_pkg::HALF_W-1:0] = first[apr_pkg::HALF_W-1:0]
                                                  + 64'($urandom_range(0, 3000));
                end
            end
            apr_pkg::RT_V6_PREFIX: begin
                r = $urandom_range(0, 19);
                if (r < 1)      detail = apr_pkg::DETAIL_W'($urandom_range(129, 255));
                else if (r < 6) detail = apr_pkg::DETAIL_W'($urandom_range(0, 1) ? 0 : 128);
                else if (r < 9) detail = apr_pkg::DETAIL_W'($urandom_range(63, 65));
            end
            default: ;
        endcase
        // swap the bounds now and then to get an inverted range
        if ($urandom_range(0, 99) < 15) begin
            hold   = first;
            first  = second;
            second = hold;
        end
        return make_rule(apr_pkg::SLOT_W'($urandom), kind, first, second, detail);
    endfunction

    // Lookup aimed at a stored rule, near its bounds, to make hits and near misses.
    function automatic t_rule_beat aim_lookup();
        int                         s;
        logic [apr_pkg::TYPE_W-1:0] kind;
        logic [apr_pkg::ADDR_W-1:0] base;
        logic [apr_pkg::ADDR_W-1:0] addr;
        logic [apr_pkg::ADDR_W-1:0] mask;
        logic                       v6;
        logic [apr_pkg::PORT_W-1:0] port;
        s    = $urandom_range(0, RULE_SLOTS - 1);
        kind = rule_kind[s];
        case ($urandom_range(0, 5))
            0: base = rule_first[s];
            1: base = rule_second[s];
            2: base = rule_first[s] - 1;
            3: base = rule_first[s] + 1;
            4: base = rule_second[s] - 1;
            default: base = rule_second[s] + 1;
        endcase
        v6   = 1'($urandom_range(0, 1));
        addr = {rand64(), rand64()};
        case (kind)
            apr_pkg::RT_V4_WILD, apr_pkg::RT_V4_RANGE: begin
                v6 = 1'b0;
                addr[apr_pkg::V4_W-1:0] = base[apr_pkg::V4_W-1:0];
                if (kind == apr_pkg::RT_V4_WILD) begin
                    for (int k = 0; k < 4; k++) begin
                        if (rule_detail[s][3-k] && $urandom_range(0, 1))
                            addr[31-8*k -: 8] = 8'($urandom);
                    end
                end
            end
            apr_pkg::RT_V6_EXACT, apr_pkg::RT_V6_RANGE: begin
                v6 = 1'b1;
                addr = base;
            end
            apr_pkg::RT_V6_PREFIX: begin
                v6 = 1'b1;
                if ($urandom_range(0, 3) != 0 && rule_detail[s] <= 8'd128) begin
                    mask = prefix_mask(rule_detail[s]);
                    addr = (rule_first[s] & mask) | (addr & ~mask);
                end else begin
                    addr = base;
                end
            end
            default: ;
        endcase
        // steer some lookups into the special IPv6 ranges
        if ($urandom_range(0, 6) == 0) begin
            v6 = 1'b1;
            case ($urandom_range(0, 3))
                0: addr[127:120] = 8'hFF;
                1: addr[127:118] = 10'b1111_1110_10;
                2: addr[127:118] = 10'b1111_1110_11;
                default: addr = '0;
            endcase
        end
        s    = $urandom_range(0, RULE_SLOTS - 1);
        port = 16'($urandom);
        if (rule_kind[s] == apr_pkg::RT_PORT_EXACT || rule_kind[s] == apr_pkg::RT_PORT_RANGE)
        begin
            case ($urandom_range(0, 3))
                0: port = rule_first[s][apr_pkg::PORT_W-1:0];
                1: port = rule_second[s][apr_pkg::PORT_W-1:0];
                2: port = rule_first[s][apr_pkg::PORT_W-1:0] - 1;
                default: port = rule_second[s][apr_pkg::PORT_W-1:0] + 1;
            endcase
        end
        return make_lookup(v6, addr, port);
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one beat, hold it until accepted, then update the shadow table
    // or queue the lookup verdict. Drop valid only when a gap follows.
    task automatic send_beat(input t_rule_beat b);
        int gap;
        i_valid        <= 1'b1;
        i_op           <= b.op;
        i_slot         <= b.slot;
        i_rule_type    <= b.rule_type;
        i_first_upper  <= b.first_upper;
        i_first_lower  <= b.first_lower;
        i_second_upper <= b.second_upper;
        i_second_lower <= b.second_lower;
        i_detail       <= b.detail;
        i_addr_upper   <= b.addr_upper;
        i_addr_lower   <= b.addr_lower;
        i_addr_is_v6   <= b.addr_is_v6;
        i_port_number  <= b.port_number;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (b.op == apr_pkg::OP_WRITE) begin
            // a slot beyond the table is ignored
            if (b.slot < RULE_SLOTS) begin
                rule_kind[b.slot]   = b.rule_type;
                rule_first[b.slot]  = {b.first_upper, b.first_lower};
                rule_second[b.slot] = {b.second_upper, b.second_lower};
                rule_detail[b.slot] = b.detail;
            end
        end else begin
            verdicts_due.push_back(match_verdict(b.addr_is_v6,
                                                 {b.addr_upper, b.addr_lower},
                                                 b.port_number));
        end
        gap = steady ? 0 : idle_span(40);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic put_rule(input logic [apr_pkg::SLOT_W-1:0] slot,
                            input logic [apr_pkg::TYPE_W-1:0] kind,
                            input logic [apr_pkg::ADDR_W-1:0] first,
                            input logic [apr_pkg::ADDR_W-1:0] second,
                            input logic [apr_pkg::DETAIL_W-1:0] detail);
        send_beat(make_rule(slot, kind, first, second, detail));
    endtask

    task automatic ask(input logic v6, input logic [apr_pkg::ADDR_W-1:0] addr,
                       input logic [apr_pkg::PORT_W-1:0] port);
        send_beat(make_lookup(v6, addr, port));
    endtask

    // Hold the request side idle until every verdict has come back, then let
    // the chain run empty.
    task automatic settle();
        i_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (RULE_SLOTS + 2) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: check every accepted result beat, and stall at random.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : check_results
        t_lookup_verdict due;
        int              n;
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: result beat with no lookup pending: addr_hit %0b port_hit %0b v6_special %0b",
                         $time, o_address_hit, o_port_hit, o_v6_special);
                fault_count++;
            end else begin
                due = verdicts_due.pop_front();
                if (o_address_hit !== due.addr_hit) begin
                    $display("%0t: address_hit expected %0b actual %0b",
                             $time, due.addr_hit, o_address_hit);
                    fault_count++;
                end
                if (o_port_hit !== due.port_hit) begin
                    $display("%0t: port_hit expected %0b actual %0b",
                             $time, due.port_hit, o_port_hit);
                    fault_count++;
                end
                if (o_v6_special !== due.v6_special) begin
                    $display("%0t: v6_special expected %0b actual %0b",
                             $time, due.v6_special, o_v6_special);
                    fault_count++;
                end
            end
        end
        // advance the stall pattern
        if (steady) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            n = idle_span(25);
            if (n > 0) begin
                stall_left = n - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Lookups against the table as reset left it: no hits at all.
    task automatic test_empty_table();
        ask(1'b0, {rand64(), 32'hFFFF_FFFF, 32'h0A14_1E28}, 16'd0);
        ask(1'b1, '0, 16'hFFFF);
        settle();
    endtask

    // Each rule type, range ends, special ranges and the odd corners.
    task automatic test_directed_rules();
        // 10.20.*.40; the high nibble of the wildcard mask is ignored
        put_rule(3'd0, apr_pkg::RT_V4_WILD, {rand64(), rand64() >> 32 << 32 | 64'h0A14_1E28},
                 {rand64(), rand64()}, 8'hF2);
        put_rule(3'd1, apr_pkg::RT_V6_PREFIX, {16'hFE80, 112'd0}, {rand64(), rand64()},
                 8'd10);
        put_rule(3'd2, apr_pkg::RT_PORT_RANGE, {rand64(), 64'd1000}, {rand64(), 64'd2000},
                 8'd0);
        // a port value above 16 bits never matches
        put_rule(3'd3, apr_pkg::RT_PORT_EXACT, {rand64(), 64'h1_0050}, {rand64(), rand64()},
                 8'd0);
        // an unused type is stored but matches nothing
        put_rule(3'd7, 4'd15, {apr_pkg::ADDR_W{1'b1}}, {apr_pkg::ADDR_W{1'b1}}, 8'hFF);
        ask(1'b0, {64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF, 32'h0A14_6328}, 16'd1000);
        ask(1'b0, {rand64(), rand64() >> 32 << 32 | 64'h0A15_1E28}, 16'd2001);
        ask(1'b1, {16'hFE80, 96'd0, 16'h0001}, 16'd2000);
        ask(1'b1, {16'hFEC0, 112'd0}, 16'h0050);
        ask(1'b1, {16'hFF02, 96'd0, 16'h0001}, 16'd999);
        put_rule(3'd4, apr_pkg::RT_V4_RANGE, {rand64(), 32'd0, 32'hC0A8_0000},
                 {rand64(), 32'd0, 32'hC0A8_FFFF}, 8'd0);
        // inverted IPv6 range
        put_rule(3'd5, apr_pkg::RT_V6_RANGE, {64'h2001_0DB8_0000_0001, 64'd0},
                 {64'h2001_0DB8_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF}, 8'd0);
        put_rule(3'd6, apr_pkg::RT_PORT_EXACT, {rand64(), 64'd0}, {rand64(), rand64()}, 8'd0);
        ask(1'b0, {rand64(), 32'd0, 32'hC0A8_FFFF}, 16'd0);
        ask(1'b0, {rand64(), 32'd0, 32'hC0A9_0000}, 16'hFFFF);
        put_rule(3'd1, apr_pkg::RT_V6_EXACT, {apr_pkg::ADDR_W{1'b1}}, {rand64(), rand64()},
                 8'd0);
        ask(1'b1, {apr_pkg::ADDR_W{1'b1}}, 16'd1500);
        // prefix length beyond 128
        put_rule(3'd0, apr_pkg::RT_V6_PREFIX, {64'h2001_0DB8_0000_0000, 64'd0},
                 {rand64(), rand64()}, 8'd129);
        put_rule(3'd5, apr_pkg::RT_V6_RANGE, {64'h2001_0DB8_0000_0000, 64'd0},
                 {64'h2001_0DB8_0000_0000, 64'hFFFF}, 8'd0);
        ask(1'b1, {64'h2001_0DB8_0000_0000, 64'hFFFF}, 16'd80);
        put_rule(3'd2, apr_pkg::RT_ANY_ADDR, {rand64(), rand64()}, {rand64(), rand64()}, 8'd0);
        put_rule(3'd3, apr_pkg::RT_ANY_PORT, {rand64(), rand64()}, {rand64(), rand64()}, 8'd0);
        ask(1'b1, {16'hFE40, 112'd1}, 16'd7);
        // pause here until every lookup has answered
        settle();
    endtask

    // Write random rules, then mostly lookups, with no idling on either side.
    task automatic test_back_to_back();
        steady = 1'b1;
        for (int s = 0; s < RULE_SLOTS; s++) begin
            send_beat(draw_rule());
        end
        for (int n = 0; n < 140; n++) begin
            if (n % 20 == 19) send_beat(draw_rule());
            else              send_beat(aim_lookup());
        end
        steady = 1'b0;
        settle();
    endtask

    // Mixed writes and lookups, mostly aimed at stored rules, with idle-free
    // stretches and periodic full drains.
    task automatic test_random_traffic(input int count);
        t_rule_beat beat;
        for (int n = 0; n < count; n++) begin
            steady = (n % 300) < 50;
            if ($urandom_range(0, 99) < 28)      beat = draw_rule();
            else if ($urandom_range(0, 99) < 82) beat = aim_lookup();
            else beat = make_lookup(1'($urandom_range(0, 1)), {rand64(), rand64()},
                                    16'($urandom));
            send_beat(beat);
            if (n % 400 == 399) settle();
        end
        steady = 1'b0;
        settle();
    endtask

    initial begin
        for (int s = 0; s < RULE_SLOTS; s++) begin
            rule_kind[s]   = apr_pkg::RT_EMPTY;
            rule_first[s]  = '0;
            rule_second[s] = '0;
            rule_detail[s] = '0;
        end
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_directed_rules();
        test_back_to_back();
        test_random_traffic(1480);

        repeat (2 * RULE_SLOTS + 10) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("address_port_rule_matcher verification clean");
        end else begin
            $display("address_port_rule_matcher verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("address_port_rule_matcher verification failed");
        $finish;
    end

endmodule
